@@ rtl/core/bitmap_change_log_with_deltas_macros.svh @@
// Assertion helpers for the RTL files.
`ifndef BITMAP_CHANGE_LOG_WITH_DELTAS_MACROS_SVH
`define BITMAP_CHANGE_LOG_WITH_DELTAS_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define BCL_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check a consequence in the same cycle as its cause.
`define BCL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check a consequence in the cycle after its cause.
`define BCL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/bcl_pkg.sv @@
package bcl_pkg;

    // Input modes
    localparam logic [1:0] MODE_MARK    = 2'd0;
    localparam logic [1:0] MODE_QUERY   = 2'd1;
    localparam logic [1:0] MODE_PRELOAD = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_SNAP_WORD   = 2'd0;
    localparam logic [1:0] KIND_DELTA_INDEX = 2'd1;
    localparam logic [1:0] KIND_EMPTY_DELTA = 2'd2;
    localparam logic [1:0] KIND_EMPTY_SNAP  = 2'd3;

    // Register map (index by word address)
    localparam logic REG_ITEM_COUNT = 1'b0;
    localparam logic REG_LOG_LIMIT  = 1'b1;

    localparam logic [12:0] ITEM_COUNT_RST = 13'd4096;
    localparam logic [6:0]  LOG_LIMIT_RST  = 7'd64;

    typedef enum logic [1:0] {
        OP_MARK,
        OP_PRELOAD,
        OP_QUERY
    } t_op;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] item_index;
        logic [31:0] start_frame;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] current_frame;
        logic [5:0]  word_number;
        logic [63:0] bitmap_word;
        logic [11:0] delta_index;
        logic        last;
    } t_result;

    // Classified command between the front and the back
    typedef struct packed {
        t_op         op;
        logic [11:0] item_index;
        logic [31:0] start_frame;
    } t_cmd;

    // Effective configuration, already clamped to the built sizes
    typedef struct packed {
        logic [12:0] eff_items;
        logic [6:0]  eff_limit;
    } t_cfg;

endpackage

@@ rtl/core/bitmap_change_log_with_deltas.sv @@
// A mark or preload is taken in S_IDLE (bitmap read issued) and applied in S_UPDATE.
// A query is taken in S_IDLE and classified in S_QUERY, then gives one empty result
// from S_EMPTY, or per result a registered RAM read (S_SNAP_RD, S_DELTA_RD) and a push
// (S_SNAP_WR, S_DELTA_WR). The back takes a new command only from S_IDLE, so it is done
// with one before the next; a full result queue holds it in its read or empty state.
// Reset (synchronous, active low) clears bitmap valid bits, log fill, queues; horizon = 1.
module bitmap_change_log_with_deltas #(
    parameter int MAX_ITEMS = 4096,
    parameter int LOG_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,

    // Item side
    input  logic             push,
    input  bcl_pkg::t_item   i_item,
    output logic             full,

    // Result side
    output logic             empty,
    output bcl_pkg::t_result o_result,
    input  logic             pop,

    // Configuration port
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import bcl_pkg::*;

    // Configuration registers, as written by software
    logic [12:0] r_item_count;
    logic [6:0]  r_log_limit;

    // Clamped view shared by front and back
    t_cfg cfg;

    // Front-to-back command queue
    t_cmd cmd;
    logic cmd_empty;
    logic cmd_pop;

    logic cfg_wr;

    // Register access: one word per 32-bit slot, byte address 4*i
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= ITEM_COUNT_RST;
            r_log_limit  <= LOG_LIMIT_RST;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_ITEM_COUNT: r_item_count <= pwdata[12:0];
                REG_LOG_LIMIT:  r_log_limit  <= pwdata[6:0];
                default:        r_item_count <= r_item_count;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ITEM_COUNT: prdata = {19'd0, r_item_count};
            REG_LOG_LIMIT:  prdata = {25'd0, r_log_limit};
            default:        prdata = 32'd0;
        endcase
    end

    // Clamp to what was built: items beyond MAX_ITEMS and log entries beyond LOG_DEPTH
    // do not exist in hardware
    assign cfg.eff_items = (r_item_count < 13'(MAX_ITEMS)) ? r_item_count : 13'(MAX_ITEMS);
    assign cfg.eff_limit = (r_log_limit < 7'(LOG_DEPTH)) ? r_log_limit : 7'(LOG_DEPTH);

    // Front: accept every word it can queue, drop out-of-range updates and the unused mode
    bcl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .o_full      (full),
        .i_cfg       (cfg),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd),
        .o_cmd_empty (cmd_empty)
    );

    // Back: bitmap and log RAMs, frame bookkeeping, result streaming into a
    // two-word output queue; the back waits while that queue is full
    bcl_back #(
        .MAX_ITEMS (MAX_ITEMS),
        .LOG_DEPTH (LOG_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

@@ rtl/core/bcl_ram.sv @@
module bcl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/bcl_queue.sv @@
module bcl_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty
);

    // Two-entry queue: holds one word while the next is written
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            case ({push_ok, pop_ok})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

@@ rtl/core/bcl_front.sv @@
module bcl_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bcl_pkg::t_item i_item,
    output logic           o_full,
    input  bcl_pkg::t_cfg  i_cfg,
    input  logic           i_cmd_pop,
    output bcl_pkg::t_cmd  o_cmd,
    output logic           o_cmd_empty
);

    import bcl_pkg::*;

    logic in_range;
    logic keep;
    t_cmd cmd;
    logic q_full;

    assign in_range = ({3'b000, i_cfg.eff_items} > i_item.item_index);

    // Drop out-of-range updates and unused modes here; they leave no trace
    always_comb begin
        keep             = 1'b0;
        cmd.op           = OP_QUERY;
        cmd.item_index   = i_item.item_index[11:0];
        cmd.start_frame  = i_item.start_frame;
        case (i_item.mode)
            MODE_MARK: begin
                keep   = in_range;
                cmd.op = OP_MARK;
            end
            MODE_PRELOAD: begin
                keep   = in_range;
                cmd.op = OP_PRELOAD;
            end
            MODE_QUERY: begin
                keep   = 1'b1;
                cmd.op = OP_QUERY;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_full = q_full;

    bcl_queue #(
        .WIDTH ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && keep),
        .i_wdata (cmd),
        .o_full  (q_full),
        .i_pop   (i_cmd_pop),
        .o_rdata (o_cmd),
        .o_empty (o_cmd_empty)
    );

endmodule

@@ rtl/core/bcl_back.sv @@
`include "bitmap_change_log_with_deltas_macros.svh"

module bcl_back #(
    parameter int MAX_ITEMS = 4096,
    parameter int LOG_DEPTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bcl_pkg::t_cfg    i_cfg,
    input  bcl_pkg::t_cmd    i_cmd,
    input  logic             i_cmd_empty,
    output logic             o_cmd_pop,
    output bcl_pkg::t_result o_result,
    output logic             o_empty,
    input  logic             i_pop
);

    import bcl_pkg::*;

    localparam int BW  = (MAX_ITEMS + 63) / 64;
    localparam int WAW = (BW > 1) ? $clog2(BW) : 1;
    localparam int RAW = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam logic [7:0] DEPTH8 = 8'(LOG_DEPTH);
    localparam logic [6:0] DEPTH7 = 7'(LOG_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_QUERY,
        S_EMPTY,
        S_SNAP_RD,
        S_SNAP_WR,
        S_DELTA_RD,
        S_DELTA_WR
    } t_state;

    function automatic logic [RAW-1:0] ring_add(input logic [RAW-1:0] base,
                                                input logic [6:0] amt);
        logic [7:0] sum;
        sum = 8'(base) + {1'b0, amt};
        if (sum >= DEPTH8) begin
            sum = sum - DEPTH8;
        end
        return sum[RAW-1:0];
    endfunction

    t_state         r_state, n_state;
    t_cmd           r_cmd, n_cmd;
    logic [RAW-1:0] r_head, n_head;
    logic [6:0]     r_count, n_count;
    logic [31:0]    r_horizon, n_horizon;
    logic [31:0]    r_cur, n_cur;
    logic [BW-1:0]  r_valid, n_valid;
    logic [6:0]     r_word, n_word;
    logic [6:0]     r_left, n_left;
    logic [RAW-1:0] r_pos, n_pos;
    logic [1:0]     r_kind, n_kind;

    logic [WAW-1:0] bm_raddr;
    logic [WAW-1:0] upd_word;
    logic [WAW-1:0] snap_word;
    logic           bm_we;
    logic [63:0]    bm_wdata;
    logic [63:0]    bm_rdata;
    logic           rg_we;
    logic [RAW-1:0] rg_waddr;
    logic [11:0]    rg_rdata;

    logic [63:0]    upd_data;
    logic [63:0]    bit_mask;
    logic           upd_new;
    logic [6:0]     drops;
    logic [31:0]    since;
    logic           want_snap;
    logic [6:0]     skip;
    logic [12:0]    rem;
    logic [63:0]    tail_mask;
    logic [6:0]     nwords;
    logic           snap_last;

    logic           oq_push;
    logic           oq_full;
    t_result        res;

    assign upd_word  = r_cmd.item_index[6 +: WAW];
    assign snap_word = r_word[WAW-1:0];
    assign bm_raddr  = (r_state == S_IDLE) ? i_cmd.item_index[6 +: WAW] : snap_word;

    assign upd_data  = r_valid[upd_word] ? bm_rdata : 64'd0;
    assign bit_mask  = 64'd1 << r_cmd.item_index[5:0];
    assign upd_new   = ((upd_data & bit_mask) == 64'd0);
    assign drops     = r_count - i_cfg.eff_limit + 7'd1;
    assign rg_waddr  = ring_add(r_head, r_count);

    assign since     = r_cmd.start_frame;
    assign want_snap = (since == 32'd0) || (since < r_horizon) || (since > r_cur);
    assign skip      = 7'(since - r_horizon);

    assign rem       = i_cfg.eff_items - {r_word, 6'b000000};
    assign tail_mask = (rem >= 13'd64) ? {64{1'b1}} : ~({64{1'b1}} << rem[5:0]);
    assign nwords    = 7'((14'(i_cfg.eff_items) + 14'd63) >> 6);
    assign snap_last = ((r_word + 7'd1) == nwords);

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_head    = r_head;
        n_count   = r_count;
        n_horizon = r_horizon;
        n_cur     = r_cur;
        n_valid   = r_valid;
        n_word    = r_word;
        n_left    = r_left;
        n_pos     = r_pos;
        n_kind    = r_kind;
        o_cmd_pop = 1'b0;
        bm_we     = 1'b0;
        bm_wdata  = upd_data | bit_mask;
        rg_we     = 1'b0;
        oq_push   = 1'b0;
        res               = '0;
        res.current_frame = r_cur;

        case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    n_state   = (i_cmd.op == OP_QUERY) ? S_QUERY : S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_IDLE;
                if (upd_new) begin
                    bm_we             = 1'b1;
                    n_valid[upd_word] = 1'b1;
                    if (r_cmd.op == OP_MARK) begin
                        n_cur = r_cur + 32'd1;
                        if (i_cfg.eff_limit == 7'd0) begin
                            n_horizon = r_horizon + 32'(r_count) + 32'd1;
                            n_head    = ring_add(r_head, r_count);
                            n_count   = 7'd0;
                        end else if (r_count >= i_cfg.eff_limit) begin
                            rg_we     = 1'b1;
                            n_horizon = r_horizon + 32'(drops);
                            n_head    = ring_add(r_head, drops);
                            n_count   = i_cfg.eff_limit;
                        end else begin
                            rg_we   = 1'b1;
                            n_count = r_count + 7'd1;
                        end
                    end
                end
            end
            S_QUERY: begin
                n_word = 7'd0;
                if (want_snap) begin
                    if (i_cfg.eff_items == 13'd0) begin
                        n_kind  = KIND_EMPTY_SNAP;
                        n_state = S_EMPTY;
                    end else begin
                        n_state = S_SNAP_RD;
                    end
                end else if (since == r_cur) begin
                    n_kind  = KIND_EMPTY_DELTA;
                    n_state = S_EMPTY;
                end else begin
                    n_pos   = ring_add(r_head, skip);
                    n_left  = r_count - skip;
                    n_state = S_DELTA_RD;
                end
            end
            S_EMPTY: begin
                res.kind = r_kind;
                res.last = 1'b1;
                if (!oq_full) begin
                    oq_push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SNAP_RD: begin
                // Read address is already r_word; wait for room downstream
                if (!oq_full) begin
                    n_state = S_SNAP_WR;
                end
            end
            S_SNAP_WR: begin
                oq_push         = 1'b1;
                res.kind        = KIND_SNAP_WORD;
                res.word_number = r_word[5:0];
                res.bitmap_word = (r_valid[snap_word] ? bm_rdata : 64'd0) & tail_mask;
                res.last        = snap_last;
                if (snap_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_word  = r_word + 7'd1;
                    n_state = S_SNAP_RD;
                end
            end
            S_DELTA_RD: begin
                if (!oq_full) begin
                    n_state = S_DELTA_WR;
                end
            end
            S_DELTA_WR: begin
                oq_push         = 1'b1;
                res.kind        = KIND_DELTA_INDEX;
                res.delta_index = rg_rdata;
                res.last        = (r_left == 7'd1);
                if (r_left == 7'd1) begin
                    n_state = S_IDLE;
                end else begin
                    n_left  = r_left - 7'd1;
                    n_pos   = ring_add(r_pos, 7'd1);
                    n_state = S_DELTA_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_head    <= '0;
            r_count   <= 7'd0;
            r_horizon <= 32'd1;
            r_cur     <= 32'd1;
            r_valid   <= '0;
        end else begin
            r_state   <= n_state;
            r_head    <= n_head;
            r_count   <= n_count;
            r_horizon <= n_horizon;
            r_cur     <= n_cur;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_word <= n_word;
        r_left <= n_left;
        r_pos  <= n_pos;
        r_kind <= n_kind;
    end

    bcl_ram #(
        .WIDTH (64),
        .DEPTH (BW)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (upd_word),
        .i_wdata (bm_wdata),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    bcl_ram #(
        .WIDTH (12),
        .DEPTH (LOG_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (rg_we),
        .i_waddr (rg_waddr),
        .i_wdata (r_cmd.item_index),
        .i_raddr (r_pos),
        .o_rdata (rg_rdata)
    );

    bcl_queue #(
        .WIDTH ($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (oq_push),
        .i_wdata (res),
        .o_full  (oq_full),
        .i_pop   (i_pop),
        .o_rdata (o_result),
        .o_empty (o_empty)
    );

    `BCL_ASSERT_ALWAYS(a_frame_sum, i_clk, i_rst_n, r_cur == r_horizon + 32'(r_count), "current frame lost track of horizon plus fill")
    `BCL_ASSERT_ALWAYS(a_count_cap, i_clk, i_rst_n, r_count <= DEPTH7, "log fill exceeds ring depth")
    `BCL_ASSERT_IMPLY(a_push_room, i_clk, i_rst_n, oq_push, !oq_full, "result pushed into a full queue")
    `BCL_ASSERT_NEXT(a_frame_step, i_clk, i_rst_n, (r_state == S_UPDATE) && upd_new && (r_cmd.op == OP_MARK), r_cur == $past(r_cur) + 32'd1, "new mark did not advance the frame by one")

endmodule

@@ tb/tb_bitmap_change_log_with_deltas.sv @@
module tb_bitmap_change_log_with_deltas;
    timeunit 1ns;
    timeprecision 1ps;

    import bcl_pkg::*;

    // Mode 3 has no meaning; the block must swallow it without a result.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int unsigned BUILT_ITEMS = 4096;
    localparam int unsigned BUILT_DEPTH = 64;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    // Marks and preloads settle after the back pops and applies them; allow a margin.
    localparam int unsigned SETTLE_CYCLES = 12;

    // ------------------------------------------------------------------
    // Completion tracker: mirrors the bitmap, the change log and the
    // registers, and holds the result words each accepted query should give.
    // ------------------------------------------------------------------
    class completion_tracker;
        logic [63:0] done_words [BUILT_DEPTH];
        logic [11:0] log_ring [BUILT_DEPTH];
        int unsigned log_head;
        int unsigned log_fill;
        logic [31:0] horizon;
        int unsigned item_count;
        int unsigned log_limit;
        t_result     pending [$];
        int unsigned errors;

        function new();
            foreach (done_words[w]) done_words[w] = '0;
            log_head   = 0;
            log_fill   = 0;
            horizon    = 32'd1;
            item_count = ITEM_COUNT_RST;
            log_limit  = LOG_LIMIT_RST;
            errors     = 0;
        endfunction

        function int unsigned live_items();
            return (item_count < BUILT_ITEMS) ? item_count : BUILT_ITEMS;
        endfunction

        function logic [31:0] frame_now();
            return horizon + log_fill;
        endfunction

        task flag(string msg);
            errors++;
            $display("  mismatch: %s", msg);
        endtask

        function void set_reg(logic idx, int unsigned value);
            if (idx == REG_ITEM_COUNT) item_count = value & 32'h1FFF;
            else log_limit = value & 32'h7F;
        endfunction

        function void queue_word(logic [1:0] kind, logic [31:0] frame, logic [5:0] word_no,
                                 logic [63:0] bits, logic [11:0] idx, logic fin);
            t_result r;
            r.kind          = kind;
            r.current_frame = frame;
            r.word_number   = word_no;
            r.bitmap_word   = bits;
            r.delta_index   = idx;
            r.last          = fin;
            pending.insert(pending.size(), r);
        endfunction

        // Apply one accepted item and queue the result words it causes.
        function void note_item(t_item it);
            int unsigned count;
            int unsigned lim;
            int unsigned nw;
            int unsigned valid;
            int unsigned w;
            int unsigned k;
            logic [31:0] now;
            logic [31:0] skip;
            logic [63:0] bits;
            count = live_items();
            case (it.mode)
                MODE_MARK, MODE_PRELOAD: begin
                    // Drop out-of-range indices and items already complete.
                    if (it.item_index >= count) return;
                    if (done_words[it.item_index[11:6]][it.item_index[5:0]]) return;
                    done_words[it.item_index[11:6]][it.item_index[5:0]] = 1'b1;
                    if (it.mode == MODE_MARK) begin
                        lim = (log_limit < BUILT_DEPTH) ? log_limit : BUILT_DEPTH;
                        // Make room: each dropped entry advances the horizon.
                        while (log_fill > 0 && log_fill >= lim) begin
                            log_head = (log_head + 1) % BUILT_DEPTH;
                            log_fill--;
                            horizon++;
                        end
                        if (lim == 0) begin
                            horizon++;
                        end else begin
                            log_ring[(log_head + log_fill) % BUILT_DEPTH] = it.item_index[11:0];
                            log_fill++;
                        end
                    end
                end
                MODE_QUERY: begin
                    now = frame_now();
                    if (it.start_frame == 0 || it.start_frame < horizon
                            || it.start_frame > now) begin
                        nw = (count + 63) / 64;
                        if (nw == 0) begin
                            queue_word(KIND_EMPTY_SNAP, now, '0, '0, '0, 1'b1);
                        end else begin
                            for (w = 0; w < nw; w++) begin
                                bits  = done_words[w];
                                valid = count - w * 64;
                                if (valid < 64) bits &= (64'd1 << valid) - 64'd1;
                                queue_word(KIND_SNAP_WORD, now, w[5:0], bits, '0, w + 1 == nw);
                            end
                        end
                    end else begin
                        skip = it.start_frame - horizon;
                        if (skip >= log_fill) begin
                            queue_word(KIND_EMPTY_DELTA, now, '0, '0, '0, 1'b1);
                        end else begin
                            for (k = skip; k < log_fill; k++) begin
                                queue_word(KIND_DELTA_INDEX, now, '0, '0,
                                           log_ring[(log_head + k) % BUILT_DEPTH],
                                           k + 1 == log_fill);
                            end
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        task cmp(string name, logic [63:0] got, logic [63:0] want);
            if (got !== want)
                flag($sformatf("%s got %0h want %0h", name, got, want));
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending.size() == 0) begin
                flag($sformatf("result word with nothing pending, kind %0d", got.kind));
                return;
            end
            want = pending[0];
            pending.delete(0);
            cmp("kind", got.kind, want.kind);
            cmp("current_frame", got.current_frame, want.current_frame);
            cmp("word_number", got.word_number, want.word_number);
            cmp("bitmap_word", got.bitmap_word, want.bitmap_word);
            cmp("delta_index", got.delta_index, want.delta_index);
            cmp("last", got.last, want.last);
        endtask
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and block inputs, all known from time zero
    // ------------------------------------------------------------------
    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    t_item       i_item  = '0;
    logic        full;
    logic        empty;
    t_result     o_result;
    logic        pop     = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    completion_tracker tracker = new();
    bit          steady   = 1'b0;   // no new idle spans on either side while set
    int unsigned pop_hold = 0;
    int unsigned cycles   = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    bitmap_change_log_with_deltas u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .empty    (empty),
        .o_result (o_result),
        .pop      (pop),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Idle span: mostly none, some short, a few long.
    function automatic int unsigned idle_span();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Result side: hold pop low for random spans unless running steady.
    always @(posedge i_clk) begin
        if (pop_hold > 0) begin
            pop      <= 1'b0;
            pop_hold <= pop_hold - 1;
        end else begin
            pop <= 1'b1;
            if (!steady) pop_hold <= idle_span();
        end
    end

    // Check every result word taken at this edge against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) tracker.check_result(o_result);
    end

    // Watchdog: stop a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offer one item word and hold it until the block takes it.
    task automatic send_item(t_item it);
        push   <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (full !== 1'b0) @(posedge i_clk);
        tracker.note_item(it);
    endtask

    // Drop push for a random span after an accepted item.
    task automatic sender_gap();
        int unsigned n;
        n = steady ? 0 : idle_span();
        if (n > 0) begin
            push <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Wait for every pending result word, then let the last update settle.
    task automatic wait_idle();
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write a register (setup then access), then read it back.
    task automatic write_reg(logic idx, int unsigned value);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        tracker.set_reg(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== value)
            tracker.flag($sformatf("register %0d read %0h want %0h", idx, got, value));
    endtask

    function automatic t_item make_item(logic [1:0] mode, logic [15:0] idx, logic [31:0] since);
        t_item it;
        it.mode        = mode;
        it.item_index  = idx;
        it.start_frame = since;
        return it;
    endfunction

    // Random item word. Most marks and queries are well formed so that the
    // log fills, overflows and wraps; the rest is out-of-range noise and the
    // unused mode. counts is low for words the block simply ignores.
    task automatic random_item(input int unsigned mark_pct, output t_item it,
                               output bit counts);
        int unsigned count;
        int unsigned r;
        count          = tracker.live_items();
        r              = $urandom_range(0, 99);
        it.start_frame = $urandom;
        it.item_index  = $urandom_range(0, 65535);
        counts         = 1'b1;
        if (r < mark_pct + 6) begin
            it.mode = (r < mark_pct) ? MODE_MARK : MODE_PRELOAD;
            if (count > 0) it.item_index = $urandom_range(0, count - 1);
            else counts = 1'b0;
        end else if (r < mark_pct + 12) begin
            // snapshot: zero, just below horizon, past the current frame, or anything
            it.mode = MODE_QUERY;
            case ($urandom_range(0, 3))
                0: it.start_frame = '0;
                1: it.start_frame = tracker.horizon - 1;
                2: it.start_frame = tracker.frame_now() + 1 + $urandom_range(0, 1000);
                default: ;
            endcase
        end else if (r < 88) begin
            it.mode        = MODE_QUERY;
            it.start_frame = tracker.horizon + $urandom_range(0, tracker.log_fill);
        end else if (r < 95) begin
            it.mode = $urandom_range(0, 1) ? MODE_MARK : MODE_PRELOAD;
            counts  = 1'b0;
        end else begin
            it.mode = MODE_UNUSED;
            counts  = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        t_item       plan [$];
        t_item       it;
        bit          counts;
        int unsigned useful;
        int unsigned ph;
        int unsigned phase_count [5];
        int unsigned phase_limit [5];
        int unsigned phase_items [5];
        int unsigned phase_marks [5];

        phase_count = '{8191, 100, 70, 0, 4096};
        phase_limit = '{40, 4, 0, 127, 64};
        phase_items = '{35, 20, 12, 5, 12};
        phase_marks = '{60, 60, 45, 20, 30};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at reset settings: bitmap edges, out-of-range and
        // repeated marks, the unused mode, and each query branch but the empty snapshot.
        plan = {};
        plan = {plan, make_item(MODE_QUERY,   16'd0,     32'd0)};
        plan = {plan, make_item(MODE_MARK,    16'd0,     32'hFFFF_FFFF)};
        plan = {plan, make_item(MODE_MARK,    16'd4095,  32'd0)};
        plan = {plan, make_item(MODE_MARK,    16'd4096,  32'd0)};
        plan = {plan, make_item(MODE_MARK,    16'hFFFF,  32'd0)};
        plan = {plan, make_item(MODE_PRELOAD, 16'd64,    32'd0)};
        plan = {plan, make_item(MODE_PRELOAD, 16'd4094,  32'd0)};
        plan = {plan, make_item(MODE_MARK,    16'd0,     32'd0)};
        plan = {plan, make_item(MODE_PRELOAD, 16'd4095,  32'd0)};
        plan = {plan, make_item(MODE_UNUSED,  16'd5,     32'd1)};
        plan = {plan, make_item(MODE_MARK,    16'hAAAA,  32'h5555_5555)};
        plan = {plan, make_item(MODE_MARK,    16'h0555,  32'hAAAA_AAAA)};
        plan = {plan, make_item(MODE_QUERY,   16'hFFFF,  32'd1)};
        plan = {plan, make_item(MODE_QUERY,   16'd0,     32'd4)};
        plan = {plan, make_item(MODE_QUERY,   16'd0,     32'd3)};
        plan = {plan, make_item(MODE_QUERY,   16'd0,     32'hFFFF_FFFF)};
        plan = {plan, make_item(MODE_QUERY,   16'd0,     32'd5)};
        foreach (plan[i]) begin
            send_item(plan[i]);
            sender_gap();
        end
        push <= 1'b0;

        // Random phases: clamped maximum count with a mid limit, then the limit
        // lowered below the fill, a zero limit, no items at all, and back to
        // the built sizes.
        for (ph = 0; ph < 5; ph++) begin
            wait_idle();
            write_reg(REG_ITEM_COUNT, phase_count[ph]);
            write_reg(REG_LOG_LIMIT, phase_limit[ph]);
            steady <= ($urandom_range(0, 3) == 0);
            useful = 0;
            while (useful < phase_items[ph]) begin
                random_item(phase_marks[ph], it, counts);
                send_item(it);
                sender_gap();
                if (counts) begin
                    useful++;
                    if (useful % 16 == 0) steady <= ($urandom_range(0, 3) == 0);
                end
            end
            push <= 1'b0;
        end

        // Drain and let any stray word show up before deciding.
        wait_idle();
        if (tracker.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
